@@ hw/rtl/sdaf_pkg.sv @@
// Shared types, constants and the power-of-ten table for the signed decimal
// field writer. No dependencies.
package sdaf_pkg;

    localparam int MAG_W = 25;
    localparam int LIM_W = 30;
    localparam int DIG_W = 4;
    localparam int CNT_W = 4;

    localparam logic [5:0] CH_SPACE = 6'h20;
    localparam logic [5:0] CH_MINUS = 6'h2D;
    localparam logic [5:0] CH_ZERO  = 6'h30;

    typedef struct packed {
        logic       neg;
        logic [7:0] col;
        logic [7:0] row;
    } meta_t;

    function automatic logic [LIM_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [LIM_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/signed_decimal_to_ascii_field.sv @@
// Top level of the signed decimal field writer: magnitude, saturation,
// digit pipeline, formatting and character serializer. Depends on sdaf_pkg
// and sdaf_digit_stage.
//
//  channel   | signals                               | beat
//  ----------+---------------------------------------+-------------------------------
//  cfg       | cfg_valid, cfg_ready, cfg_data        | digit_count
//  s_axis    | s_axis_tvalid/tready/tdata            | number, start_column, row
//  m_axis    | m_axis_tvalid/tready/tdata/tlast      | one character write
//
// One character leaves per cycle unless m_axis_tready holds it, digit_count+1
// beats per item (8 at reset; 0 acts as 1, values over MAX_DIGITS clamp); the
// serializer sets the rate and loads the next field in the cycle the last
// beat is taken. Reset clears valid bits and sets digit_count to 7. A held
// output beat freezes the whole pipeline once the format stage is full.
module signed_decimal_to_ascii_field #(
    parameter int MAX_DIGITS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,       // digit_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // number[24:0], start_column[32:25], row[40:33]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // char_code[5:0], column[13:6], row_out[21:14]
    output logic        m_axis_tlast    // last
);

    localparam int MW  = sdaf_pkg::MAG_W;
    localparam int DW  = sdaf_pkg::DIG_W;
    localparam int CW  = sdaf_pkg::CNT_W;
    localparam int LST = MAX_DIGITS - 1;

    logic [2:0]              dc_reg;
    logic [CW-1:0]           dc_eff;
    logic                    en;

    logic [MW-1:0]           number;
    sdaf_pkg::meta_t         in_meta;

    logic                    s0_valid_reg;
    sdaf_pkg::meta_t         s0_meta_reg;
    logic [MW-1:0]           s0_mag_reg;

    logic [sdaf_pkg::LIM_W-1:0] limit;
    logic [MW-1:0]           sat_next;
    logic                    s1_valid_reg;
    sdaf_pkg::meta_t         s1_meta_reg;
    logic [MW-1:0]           s1_mag_reg;

    logic                    v_w    [MAX_DIGITS];
    sdaf_pkg::meta_t         meta_w [MAX_DIGITS];
    logic [MW-1:0]           rem_w  [MAX_DIGITS];
    logic [DW*MAX_DIGITS-1:0] dig_w [MAX_DIGITS];

    logic [DW-1:0]           dig [MAX_DIGITS];
    logic [CW-1:0]           n_sig;
    logic [5:0]              chr_next [MAX_DIGITS+1];
    logic                    fmt_valid_reg;
    sdaf_pkg::meta_t         fmt_meta_reg;
    logic [5:0]              fmt_chr_reg [MAX_DIGITS+1];

    logic                    busy_reg, busy_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [7:0]              col_reg, col_next;
    logic [7:0]              row_reg, row_next;
    logic [5:0]              chr_reg  [MAX_DIGITS+1];
    logic [5:0]              chr_sh   [MAX_DIGITS+1];
    logic                    out_acc;
    logic                    ser_last;
    logic                    ser_load;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= 3'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dc_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (dc_reg == 3'd0)
        begin
            dc_eff = CW'(1);
        end
        else if ({1'b0, dc_reg} > CW'(MAX_DIGITS))
        begin
            dc_eff = CW'(MAX_DIGITS);
        end
        else
        begin
            dc_eff = {1'b0, dc_reg};
        end
    end

    // pipeline control
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign ser_last      = (k_reg == dc_eff);
    assign ser_load      = fmt_valid_reg && (!busy_reg || (out_acc && ser_last));
    assign en            = !fmt_valid_reg || ser_load;
    assign s_axis_tready = en;

    // stage 0: sign and magnitude
    assign number      = s_axis_tdata[24:0];
    assign in_meta.neg = number[MW-1];
    assign in_meta.col = s_axis_tdata[32:25];
    assign in_meta.row = s_axis_tdata[40:33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= s_axis_tvalid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_meta_reg <= in_meta;
            s0_mag_reg  <= number[MW-1] ? MW'(~number + MW'(1)) : number;
            s1_meta_reg <= s0_meta_reg;
            s1_mag_reg  <= sat_next;
        end
    end

    // stage 1: saturate to digit_count nines
    assign limit = sdaf_pkg::pow10(dc_eff) - sdaf_pkg::LIM_W'(1);

    always_comb
    begin
        if ({{(sdaf_pkg::LIM_W - MW){1'b0}}, s0_mag_reg} > limit)
        begin
            sat_next = limit[MW-1:0];
        end
        else
        begin
            sat_next = s0_mag_reg;
        end
    end

    // digit stages, most significant first; the units digit is what remains
    assign v_w[0]    = s1_valid_reg;
    assign meta_w[0] = s1_meta_reg;
    assign rem_w[0]  = s1_mag_reg;
    assign dig_w[0]  = '0;

    for (genvar j = 0; j < MAX_DIGITS - 1; j++)
    begin : g_dig
        sdaf_digit_stage #(
            .MAX_DIGITS(MAX_DIGITS),
            .POS       (j)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_w[j]),
            .in_meta   (meta_w[j]),
            .in_rem    (rem_w[j]),
            .in_digits (dig_w[j]),
            .out_valid (v_w[j+1]),
            .out_meta  (meta_w[j+1]),
            .out_rem   (rem_w[j+1]),
            .out_digits(dig_w[j+1])
        );
    end

    // format stage
    always_comb
    begin
        for (int m = 0; m < MAX_DIGITS - 1; m++)
        begin
            dig[m] = dig_w[LST][m*DW +: DW];
        end
        dig[LST] = rem_w[LST][DW-1:0];

        n_sig = CW'(1);
        for (int j = MAX_DIGITS - 1; j >= 0; j--)
        begin
            if (dig[j] != '0)
            begin
                n_sig = CW'(MAX_DIGITS - j);
            end
        end

        chr_next[0] = meta_w[LST].neg ? sdaf_pkg::CH_MINUS : sdaf_pkg::CH_SPACE;
        for (int k = 1; k <= MAX_DIGITS; k++)
        begin
            chr_next[k] = sdaf_pkg::CH_SPACE;
            for (int m = 0; m < MAX_DIGITS; m++)
            begin
                if ({1'b0, n_sig} + (CW+1)'(m) == (CW+1)'(MAX_DIGITS - 1 + k))
                begin
                    chr_next[k] = sdaf_pkg::CH_ZERO | {2'b00, dig[m]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fmt_valid_reg <= v_w[LST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmt_meta_reg <= meta_w[LST];
            fmt_chr_reg  <= chr_next;
        end
    end

    // serializer
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            chr_sh[i] = chr_reg[i+1];
        end
        chr_sh[MAX_DIGITS] = sdaf_pkg::CH_SPACE;

        busy_next = busy_reg;
        k_next    = k_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (ser_load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            col_next  = fmt_meta_reg.col;
            row_next  = fmt_meta_reg.row;
        end
        else if (out_acc)
        begin
            if (ser_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next   = k_reg + CW'(1);
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        if (ser_load)
        begin
            chr_reg <= fmt_chr_reg;
        end
        else if (out_acc)
        begin
            chr_reg <= chr_sh;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {2'b00, row_reg, col_reg, chr_reg[0]};
    assign m_axis_tlast  = ser_last;

endmodule

@@ hw/rtl/sdaf_digit_stage.sv @@
// One pipeline stage of decimal digit extraction by compare and subtract.
// Depends on sdaf_pkg.
module sdaf_digit_stage #(
    parameter int MAX_DIGITS = 7,
    parameter int POS        = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  sdaf_pkg::meta_t                      in_meta,
    input  logic [sdaf_pkg::MAG_W-1:0]           in_rem,
    input  logic [sdaf_pkg::DIG_W*MAX_DIGITS-1:0] in_digits,
    output logic                                 out_valid,
    output sdaf_pkg::meta_t                      out_meta,
    output logic [sdaf_pkg::MAG_W-1:0]           out_rem,
    output logic [sdaf_pkg::DIG_W*MAX_DIGITS-1:0] out_digits
);

    localparam logic [sdaf_pkg::LIM_W-1:0] PWR =
        sdaf_pkg::pow10(sdaf_pkg::CNT_W'(MAX_DIGITS - 1 - POS));

    logic [sdaf_pkg::LIM_W-1:0]            rem_ext;
    logic [sdaf_pkg::DIG_W-1:0]            digit;
    logic [sdaf_pkg::MAG_W-1:0]            rem_next;
    logic [sdaf_pkg::DIG_W*MAX_DIGITS-1:0] digits_next;

    logic                                  valid_reg;
    sdaf_pkg::meta_t                       meta_reg;
    logic [sdaf_pkg::MAG_W-1:0]            rem_reg;
    logic [sdaf_pkg::DIG_W*MAX_DIGITS-1:0] digits_reg;

    assign rem_ext = {{(sdaf_pkg::LIM_W - sdaf_pkg::MAG_W){1'b0}}, in_rem};

    // compares are monotonic in d, so the last hit is the digit
    always_comb
    begin
        digit    = '0;
        rem_next = in_rem;
        for (int d = 1; d <= 9; d++)
        begin
            if (rem_ext >= sdaf_pkg::LIM_W'(d) * PWR)
            begin
                digit    = sdaf_pkg::DIG_W'(d);
                rem_next = sdaf_pkg::MAG_W'(rem_ext - sdaf_pkg::LIM_W'(d) * PWR);
            end
        end
        digits_next = in_digits;
        digits_next[POS*sdaf_pkg::DIG_W +: sdaf_pkg::DIG_W] = digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg   <= in_meta;
            rem_reg    <= rem_next;
            digits_reg <= digits_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_meta   = meta_reg;
    assign out_rem    = rem_reg;
    assign out_digits = digits_reg;

endmodule

@@ hw/rtl/sdaf_checker.sv @@
// Port-level checks on the character output stream, bound to the top level.
// Depends on sdaf_pkg and signed_decimal_to_ascii_field.
module sdaf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic acc;
    assign acc = m_axis_tvalid && m_axis_tready;

    // held beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // inside a field the column steps by one and the next beat is already there
    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[13:6] == $past(m_axis_tdata[13:6]) + 8'd1))
        else $error("column did not advance within a field");

    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !m_axis_tlast |=> m_axis_tdata[21:14] == $past(m_axis_tdata[21:14]))
        else $error("row changed within a field");

    // minus only in the sign position
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !m_axis_tlast |=> m_axis_tdata[5:0] != sdaf_pkg::CH_MINUS)
        else $error("minus sign after the first position");

endmodule

bind signed_decimal_to_ascii_field sdaf_checker u_sdaf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
